[src/lvpt_pkg.sv]
// shared types and codes for the load value prediction table
package lvpt_pkg;

	localparam int CONF_W = 4;
	localparam int WORD_W = 64;
	localparam int IDX_OUT_W = 10;

	// request kinds
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_UPDATE = 1'b1;

	// configuration register indexes
	localparam logic CFG_THRESHOLD = 1'b0;
	localparam logic CFG_COUNTER_MAX = 1'b1;

	localparam logic [CONF_W-1:0] THRESHOLD_RESET = 4'd2;
	localparam logic [CONF_W-1:0] COUNTER_MAX_RESET = 4'd3;

	typedef struct packed {
		logic kind;
		logic [WORD_W-1:0] pc;
		logic [WORD_W-1:0] load_value;
		logic [WORD_W-1:0] load_address;
		logic was_correct;
		logic was_constant;
	} req_t;

	typedef struct packed {
		logic hit;
		logic is_constant;
		logic [WORD_W-1:0] predicted_value;
		logic [WORD_W-1:0] echoed_pc;
		logic [IDX_OUT_W-1:0] entry_index;
		logic [WORD_W-1:0] stored_address;
		logic [CONF_W-1:0] confidence;
	} rsp_t;

	// write-back controls from the update logic
	typedef struct packed {
		logic entry_we;
		logic lct_we;
		logic [CONF_W-1:0] lct_data;
	} wr_ctl_t;

endpackage

[src/lvpt_chan_if.sv]
// valid/ready channel carrying one payload per transaction
interface lvpt_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/lvpt_ram.sv]
// generic single-port-write, single-port-read ram with registered read
module lvpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[src/lvpt_update.sv]
// tag compare, result build and counter / entry write-back logic
module lvpt_update #(
	parameter int IDXW = 10
) (
	input logic active,
	input lvpt_pkg::req_t req,
	input logic [1+(lvpt_pkg::WORD_W-IDXW)+2*lvpt_pkg::WORD_W-1:0] entry_rd,
	input logic [lvpt_pkg::CONF_W-1:0] cnt,
	input logic [lvpt_pkg::CONF_W-1:0] threshold,
	input logic [lvpt_pkg::CONF_W-1:0] counter_max,
	output lvpt_pkg::rsp_t rsp,
	output lvpt_pkg::wr_ctl_t wr,
	output logic [1+(lvpt_pkg::WORD_W-IDXW)+2*lvpt_pkg::WORD_W-1:0] entry_wr
);
	localparam int TAGW = lvpt_pkg::WORD_W - IDXW;
	localparam int W = lvpt_pkg::WORD_W;

	logic e_valid;
	logic [TAGW-1:0] e_tag;
	logic [W-1:0] e_value;
	logic [W-1:0] e_addr;
	logic hit;
	logic is_update;

	assign {e_valid, e_tag, e_value, e_addr} = entry_rd;
	assign hit = e_valid && (e_tag == req.pc[W-1:IDXW]);
	assign is_update = active && (req.kind == lvpt_pkg::KIND_UPDATE) && req.was_constant;

	always_comb begin
		rsp = '0;
		if (hit) begin
			rsp.hit = 1'b1;
			rsp.is_constant = (cnt >= threshold);
			rsp.predicted_value = e_value;
			rsp.echoed_pc = req.pc;
			rsp.entry_index = lvpt_pkg::IDX_OUT_W'(req.pc[IDXW-1:0]);
			rsp.stored_address = e_addr;
			rsp.confidence = cnt;
		end
	end

	always_comb begin
		wr = '0;
		if (is_update) begin
			if (!req.was_correct) begin
				// misprediction: back off and retrain the entry
				wr.entry_we = 1'b1;
				wr.lct_we = 1'b1;
				wr.lct_data = (cnt == '0) ? '0 : cnt - 1'b1;
			end else if (cnt < counter_max) begin
				wr.lct_we = 1'b1;
				wr.lct_data = cnt + 1'b1;
			end
		end
	end

	assign entry_wr = {1'b1, req.pc[W-1:IDXW], req.load_value, req.load_address};
endmodule

[src/load_value_predictor_table.sv]
// top level of the load value prediction table
//
//  channel | dir | payload      | transaction
//  --------+-----+--------------+--------------------------------------------
//  req     | in  | lvpt_pkg::req_t | one lookup or update per load
//  rsp     | out | lvpt_pkg::rsp_t | one result per lookup, none per update
//  cfg     | in  | index + 4 bits  | register write when cfg_wr_en is high
//
// each transaction issues the table reads in its accept cycle; ST_LOOK then sees
// the registered read data and, for an update, writes back.
// after reset a clearing pass zeroes both tables, during which req.ready
// stays low; configuration writes are taken throughout.
// a lookup result waits in an output register; a stalled rsp holds the block
// in ST_LOOK until the output register frees up.
module load_value_predictor_table #(
	parameter int TABLE_SIZE = 1024
) (
	input logic clk,
	input logic arst_n,
	lvpt_chan_if.sink req,
	lvpt_chan_if.source rsp,
	input logic cfg_wr_en,
	input logic cfg_index,
	input logic [lvpt_pkg::CONF_W-1:0] cfg_data
);
	localparam int IDXW = $clog2(TABLE_SIZE);
	localparam int LCT_SIZE = TABLE_SIZE / 4;
	localparam int LCTW = IDXW - 2;
	localparam int W = lvpt_pkg::WORD_W;
	localparam int ENTRY_W = 1 + (W - IDXW) + 2 * W;
	localparam logic [IDXW-1:0] CLR_LAST = IDXW'(TABLE_SIZE - 1);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK} state_t;

	state_t state_q;
	logic [IDXW-1:0] clr_cnt_q;
	logic [lvpt_pkg::CONF_W-1:0] threshold_q;
	logic [lvpt_pkg::CONF_W-1:0] counter_max_q;
	lvpt_pkg::req_t req_s1;
	lvpt_pkg::rsp_t rsp_q;
	logic rsp_valid_q;

	logic accept;
	logic look;
	logic rsp_load;
	lvpt_pkg::rsp_t rsp_next;
	lvpt_pkg::wr_ctl_t wr;
	logic [ENTRY_W-1:0] entry_rd;
	logic [ENTRY_W-1:0] entry_upd;
	logic [lvpt_pkg::CONF_W-1:0] cnt_rd;

	// table port muxing between clearing pass and write-back
	logic entry_we;
	logic [IDXW-1:0] entry_waddr;
	logic [ENTRY_W-1:0] entry_wdata;
	logic lct_we;
	logic [LCTW-1:0] lct_waddr;
	logic [lvpt_pkg::CONF_W-1:0] lct_wdata;

	assign req.ready = (state_q == ST_IDLE);
	assign accept = req.valid && req.ready;
	assign look = (state_q == ST_LOOK);
	// lookup result moves into the output register once it is free
	assign rsp_load = look && (req_s1.kind == lvpt_pkg::KIND_READ) && (!rsp_valid_q || rsp.ready);

	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	always_comb begin
		if (state_q == ST_CLEAR) begin
			entry_we = 1'b1;
			entry_waddr = clr_cnt_q;
			entry_wdata = '0;
			lct_we = 1'b1;
			lct_waddr = clr_cnt_q[LCTW-1:0];
			lct_wdata = '0;
		end else begin
			entry_we = wr.entry_we;
			entry_waddr = req_s1.pc[IDXW-1:0];
			entry_wdata = entry_upd;
			lct_we = wr.lct_we;
			lct_waddr = req_s1.pc[IDXW-1:2];
			lct_wdata = wr.lct_data;
		end
	end

	// value table: valid, tag, value, address per entry
	lvpt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SIZE)
	) u_value_ram (
		.clk(clk),
		.we(entry_we),
		.waddr(entry_waddr),
		.wdata(entry_wdata),
		.re(accept),
		.raddr(req.data.pc[IDXW-1:0]),
		.rdata(entry_rd)
	);

	// confidence counters, four value entries share one
	lvpt_ram #(
		.WIDTH(lvpt_pkg::CONF_W),
		.DEPTH(LCT_SIZE)
	) u_lct_ram (
		.clk(clk),
		.we(lct_we),
		.waddr(lct_waddr),
		.wdata(lct_wdata),
		.re(accept),
		.raddr(req.data.pc[IDXW-1:2]),
		.rdata(cnt_rd)
	);

	lvpt_update #(
		.IDXW(IDXW)
	) u_update (
		.active(look),
		.req(req_s1),
		.entry_rd(entry_rd),
		.cnt(cnt_rd),
		.threshold(threshold_q),
		.counter_max(counter_max_q),
		.rsp(rsp_next),
		.wr(wr),
		.entry_wr(entry_upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_cnt_q <= '0;
			threshold_q <= lvpt_pkg::THRESHOLD_RESET;
			counter_max_q <= lvpt_pkg::COUNTER_MAX_RESET;
			req_s1 <= '0;
			rsp_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					lvpt_pkg::CFG_THRESHOLD: threshold_q <= cfg_data;
					lvpt_pkg::CFG_COUNTER_MAX: counter_max_q <= cfg_data;
					default: ;
				endcase
			end
			if (rsp_load) begin
				rsp_q <= rsp_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						req_s1 <= req.data;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (req_s1.kind == lvpt_pkg::KIND_READ) begin
						// read data stays put while the output register is busy
						if (rsp_load) begin
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
